@@ sv/grfs_pkg.sv @@
// grfs_pkg: shared widths, codes, constants and the arctangent table for the
// haversine radius filter. Used by every module of geo_radius_filter_sort.
// No dependencies.
package grfs_pkg;

    localparam int STORE_DEPTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int LAT_W     = 30;
    localparam int LON_W     = 31;
    localparam int ATTR_W    = 8;
    localparam int DIST_W    = 25;
    localparam int CMD_W     = 2;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int RAD_W     = 25;

    localparam int ANG_W  = 34;
    localparam int CRD_W  = 34;
    localparam int TRG_W  = 32;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int A_W    = 61;
    localparam int SQ_W   = 64;
    localparam int STEP_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_USER_LAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USER_LON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    localparam logic signed [ANG_W-1:0] TURN_UNITS   = 34'sd3019898880;
    localparam logic signed [ANG_W-1:0] QUAD_UNITS   = 34'sd754974720;
    localparam logic signed [MUL_W-1:0] K_LO         = 33'sd54346;
    localparam logic signed [MUL_W-1:0] K_HI         = 33'sd73204;
    localparam int                      K_SPLIT      = 17;
    localparam logic signed [CRD_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [TRG_W-1:0] ONE_Q30      = 32'sd1073741824;
    localparam logic [A_W-1:0]          ONE_Q60      = 61'h1000_0000_0000_0000;
    localparam logic [SQ_W-1:0]         SQ_BIT_START = 64'h4000_0000_0000_0000;
    localparam logic signed [MUL_W-1:0] EARTH_DIAM_M = 33'sd12742000;
    localparam logic [DIST_W-1:0]       MAX_DIST     = 25'd20015087;
    localparam logic [STEP_W-1:0]       SQ_LAST_STEP = 5'd31;

    typedef logic [4:0] t_op;
    localparam t_op OP_NOP    = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_ANGLE  = 5'd2;
    localparam t_op OP_REDUCE = 5'd3;
    localparam t_op OP_QUAD   = 5'd4;
    localparam t_op OP_MUL    = 5'd5;
    localparam t_op OP_ACCSET = 5'd6;
    localparam t_op OP_ACCADD = 5'd7;
    localparam t_op OP_ZINIT  = 5'd8;
    localparam t_op OP_ROT    = 5'd9;
    localparam t_op OP_TRIG   = 5'd10;
    localparam t_op OP_TU     = 5'd11;
    localparam t_op OP_ACLAMP = 5'd12;
    localparam t_op OP_SQINIT = 5'd13;
    localparam t_op OP_SQSTEP = 5'd14;
    localparam t_op OP_SQSAVE = 5'd15;
    localparam t_op OP_VINIT  = 5'd16;
    localparam t_op OP_VEC    = 5'd17;
    localparam t_op OP_DIST   = 5'd18;
    localparam t_op OP_CMP    = 5'd19;
    localparam t_op OP_INS    = 5'd20;
    localparam t_op OP_CLR    = 5'd21;
    localparam t_op OP_EMIT   = 5'd22;

    localparam logic [2:0] MS_KL   = 3'd0;
    localparam logic [2:0] MS_KH   = 3'd1;
    localparam logic [2:0] MS_C1S2 = 3'd2;
    localparam logic [2:0] MS_C2S2 = 3'd3;
    localparam logic [2:0] MS_S1S1 = 3'd4;
    localparam logic [2:0] MS_TU   = 3'd5;
    localparam logic [2:0] MS_Z    = 3'd6;

    typedef struct packed {
        t_op        op;
        logic [2:0] sel;
    } t_cmd;

    typedef struct packed {
        logic step_last;
        logic sq_last;
        logic ya_zero;
        logic in_radius;
        logic cnt_le1;
        logic out_free;
    } t_status;

    function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ sv/geo_radius_filter_sort.sv @@
// geo_radius_filter_sort: top level of the haversine radius filter with a
// distance-sorted store. Depends on grfs_pkg, grfs_ctrl, grfs_datapath.
//
// Usage: configure user latitude, longitude and radius through the write
// port while the block is idle. Items enter on the input valid/ready channel.
// An add item runs the distance computation on one shared CORDIC, sqrt and
// multiplier datapath, with ready low until it is done: four CORDIC rotation
// passes, two 32-step square roots, and a vectoring pass that is skipped
// when the distance is zero. A clear item empties the store without leaving
// idle, and clears the overflow flag. A finish item emits the sorted
// list, one item per cycle on the output valid/ready channel while the
// receiver takes them, with last_of_list on the final item; an empty store
// gives one item with none_found set. The output register holds a finished
// item while the next input item is accepted. A stalled receiver holds the
// output item and the finish sequence waits. Reset empties the store, clears
// the overflow flag and the configuration registers; no clearing pass.
module geo_radius_filter_sort #(
    parameter int STORE_DEPTH  = grfs_pkg::STORE_DEPTH_DEF,
    parameter int CORDIC_STEPS = grfs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [grfs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [grfs_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [grfs_pkg::CMD_W-1:0]          i_command,
    input  logic [grfs_pkg::LAT_W-1:0]          i_point_latitude,
    input  logic [grfs_pkg::LON_W-1:0]          i_point_longitude,
    input  logic [grfs_pkg::ATTR_W-1:0]         i_access_code,
    input  logic [grfs_pkg::ATTR_W-1:0]         i_kind_code,
    input  logic [grfs_pkg::ATTR_W-1:0]         i_fee_code,
    input  logic [grfs_pkg::ATTR_W-1:0]         i_accessibility_code,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [grfs_pkg::LAT_W-1:0]          o_out_latitude,
    output logic [grfs_pkg::LON_W-1:0]          o_out_longitude,
    output logic [grfs_pkg::ATTR_W-1:0]         o_out_access,
    output logic [grfs_pkg::ATTR_W-1:0]         o_out_kind,
    output logic [grfs_pkg::ATTR_W-1:0]         o_out_fee,
    output logic [grfs_pkg::ATTR_W-1:0]         o_out_accessibility,
    output logic [grfs_pkg::DIST_W-1:0]         o_out_distance,
    output logic                                o_none_found,
    output logic                                o_overflowed,
    output logic                                o_last_of_list
);
    import grfs_pkg::*;

    t_cmd                  cmd;
    t_status               status;
    logic [4*ATTR_W-1:0]   out_attr;

    grfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_command  (i_command),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    grfs_datapath #(
        .STORE_DEPTH  (STORE_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wen         (i_cfg_wen),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_point_latitude  (i_point_latitude),
        .i_point_longitude (i_point_longitude),
        .i_attr            ({i_accessibility_code, i_fee_code, i_kind_code, i_access_code}),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_out_latitude    (o_out_latitude),
        .o_out_longitude   (o_out_longitude),
        .o_out_attr        (out_attr),
        .o_out_distance    (o_out_distance),
        .o_none_found      (o_none_found),
        .o_overflowed      (o_overflowed),
        .o_last_of_list    (o_last_of_list)
    );

    assign o_out_access        = out_attr[ATTR_W-1:0];
    assign o_out_kind          = out_attr[2*ATTR_W-1:ATTR_W];
    assign o_out_fee           = out_attr[3*ATTR_W-1:2*ATTR_W];
    assign o_out_accessibility = out_attr[4*ATTR_W-1:3*ATTR_W];

endmodule

@@ sv/grfs_datapath.sv @@
// grfs_datapath: config registers, CORDIC/sqrt/multiply datapath, sorted store
// and output register for the radius filter. Depends on grfs_pkg.
module grfs_datapath #(
    parameter int STORE_DEPTH  = grfs_pkg::STORE_DEPTH_DEF,
    parameter int CORDIC_STEPS = grfs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_wen,
    input  logic [grfs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [grfs_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic [grfs_pkg::LAT_W-1:0]              i_point_latitude,
    input  logic [grfs_pkg::LON_W-1:0]              i_point_longitude,
    input  logic [4*grfs_pkg::ATTR_W-1:0]           i_attr,
    input  grfs_pkg::t_cmd                          i_cmd,
    output grfs_pkg::t_status                       o_status,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic [grfs_pkg::LAT_W-1:0]              o_out_latitude,
    output logic [grfs_pkg::LON_W-1:0]              o_out_longitude,
    output logic [4*grfs_pkg::ATTR_W-1:0]           o_out_attr,
    output logic [grfs_pkg::DIST_W-1:0]             o_out_distance,
    output logic                                    o_none_found,
    output logic                                    o_overflowed,
    output logic                                    o_last_of_list
);
    import grfs_pkg::*;

    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int ATTR4W = 4 * ATTR_W;

    logic [LAT_W-1:0] r_ulat;
    logic [LON_W-1:0] r_ulon;
    logic [RAD_W-1:0] r_radius;
    logic [LAT_W-1:0] r_plat;
    logic [LON_W-1:0] r_plon;
    logic [ATTR4W-1:0] r_pattr;

    logic signed [ANG_W-1:0]  r_ang;
    logic [1:0]               r_quad;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [CRD_W-1:0]  r_x, r_y, r_z;
    logic [STEP_W-1:0]        r_i;
    logic signed [TRG_W-1:0]  r_s1, r_s2, r_c1, r_c2, r_t, r_u;
    logic [A_W-1:0]           r_a;
    logic [SQ_W-1:0]          r_n, r_res, r_bit;
    logic [31:0]              r_ya, r_xb;
    logic [DIST_W-1:0]        r_dist;
    logic [STORE_DEPTH-1:0]   r_le;

    logic [LAT_W-1:0]  r_kl  [STORE_DEPTH];
    logic [LON_W-1:0]  r_kn  [STORE_DEPTH];
    logic [ATTR4W-1:0] r_ka  [STORE_DEPTH];
    logic [DIST_W-1:0] r_kd  [STORE_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic              r_out_valid;

    logic [LAT_W-1:0]  r_o_lat;
    logic [LON_W-1:0]  r_o_lon;
    logic [ATTR4W-1:0] r_o_attr;
    logic [DIST_W-1:0] r_o_dist;
    logic              r_o_none, r_o_ovf, r_o_last;

    logic signed [ANG_W-1:0]  ang_sel;
    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [CRD_W-1:0]  dx, dy, at;
    logic signed [CRD_W-1:0]  cs_raw, sn_raw;
    logic [SQ_W-1:0]          trial;
    logic signed [PROD_W-1:0] rnd, dd;
    logic                     full;

    function automatic logic signed [TRG_W-1:0] clamp_unit(input logic signed [CRD_W-1:0] v);
        if (v > CRD_W'(ONE_Q30)) begin
            return ONE_Q30;
        end else if (v < -CRD_W'(ONE_Q30)) begin
            return -ONE_Q30;
        end
        return TRG_W'(v);
    endfunction

    always_comb begin
        unique case (i_cmd.sel[1:0])
            2'd0: ang_sel = {{4{r_plat[LAT_W-1]}}, r_plat} - {{4{r_ulat[LAT_W-1]}}, r_ulat};
            2'd1: ang_sel = {{3{r_plon[LON_W-1]}}, r_plon} - {{3{r_ulon[LON_W-1]}}, r_ulon};
            2'd2: ang_sel = {{3{r_ulat[LAT_W-1]}}, r_ulat, 1'b0};
            2'd3: ang_sel = {{3{r_plat[LAT_W-1]}}, r_plat, 1'b0};
        endcase
    end

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (i_cmd.sel)
            MS_KL:   begin ma = {3'b0, r_ang[29:0]}; mb = K_LO; end
            MS_KH:   begin ma = {3'b0, r_ang[29:0]}; mb = K_HI; end
            MS_C1S2: begin ma = {r_c1[TRG_W-1], r_c1}; mb = {r_s2[TRG_W-1], r_s2}; end
            MS_C2S2: begin ma = {r_c2[TRG_W-1], r_c2}; mb = {r_s2[TRG_W-1], r_s2}; end
            MS_S1S1: begin ma = {r_s1[TRG_W-1], r_s1}; mb = {r_s1[TRG_W-1], r_s1}; end
            MS_TU:   begin ma = {r_t[TRG_W-1], r_t}; mb = {r_u[TRG_W-1], r_u}; end
            MS_Z:    begin ma = r_z[CRD_W-1] ? '0 : r_z[MUL_W-1:0]; mb = EARTH_DIAM_M; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_comb begin
        dx    = r_y >>> r_i;
        dy    = r_x >>> r_i;
        at    = {2'b0, atan_q30(r_i)};
        trial = r_res + r_bit;
        rnd   = (r_prod + PROD_W'(64'sd536870912)) >>> 30;
        dd    = (r_prod + PROD_W'(64'sd536870912)) >>> 30;
        full  = (r_count == CNT_W'(STORE_DEPTH));
        unique case (r_quad)
            2'd0: begin cs_raw = r_x;  sn_raw = r_y;  end
            2'd1: begin cs_raw = -r_y; sn_raw = r_x;  end
            2'd2: begin cs_raw = -r_x; sn_raw = -r_y; end
            2'd3: begin cs_raw = r_y;  sn_raw = -r_x; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ulat      <= '0;
            r_ulon      <= '0;
            r_radius    <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
        end else begin
            if (i_cfg_wen) begin
                unique case (i_cfg_index)
                    REG_USER_LAT: r_ulat   <= i_cfg_data[LAT_W-1:0];
                    REG_USER_LON: r_ulon   <= i_cfg_data[LON_W-1:0];
                    REG_RADIUS:   r_radius <= i_cfg_data[RAD_W-1:0];
                    default:      ;
                endcase
            end
            if (r_out_valid && i_out_ready && (i_cmd.op != OP_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_ZINIT, OP_SQINIT, OP_VINIT: r_i <= '0;
                OP_ROT, OP_SQSTEP, OP_VEC:     r_i <= r_i + 1'b1;
                OP_INS: begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_CLR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    if (r_count <= CNT_W'(1)) begin
                        r_ovf <= 1'b0;
                    end
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_plat  <= i_point_latitude;
                r_plon  <= i_point_longitude;
                r_pattr <= i_attr;
            end
            OP_ANGLE: r_ang <= ang_sel;
            OP_REDUCE: begin
                if (r_ang < 0) begin
                    r_ang <= r_ang + TURN_UNITS;
                end else if (r_ang >= TURN_UNITS) begin
                    r_ang <= r_ang - TURN_UNITS;
                end
            end
            OP_QUAD: begin
                priority if (r_ang >= 3 * QUAD_UNITS) begin
                    r_quad <= 2'd3;
                    r_ang  <= r_ang - 3 * QUAD_UNITS;
                end else if (r_ang >= 2 * QUAD_UNITS) begin
                    r_quad <= 2'd2;
                    r_ang  <= r_ang - 2 * QUAD_UNITS;
                end else if (r_ang >= QUAD_UNITS) begin
                    r_quad <= 2'd1;
                    r_ang  <= r_ang - QUAD_UNITS;
                end else begin
                    r_quad <= 2'd0;
                end
            end
            OP_MUL:    r_prod <= ma * mb;
            OP_ACCSET: r_acc <= r_prod;
            OP_ACCADD: r_acc <= i_cmd.sel[0] ? r_acc + (r_prod <<< K_SPLIT) : r_acc + r_prod;
            OP_ZINIT: begin
                r_z <= CRD_W'((r_acc + PROD_W'(64'sd2147483648)) >>> 32);
                r_x <= CORDIC_START;
                r_y <= '0;
            end
            OP_ROT: begin
                if (!r_z[CRD_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
            end
            OP_TRIG: begin
                unique case (i_cmd.sel[1:0])
                    2'd0: r_s1 <= clamp_unit(sn_raw);
                    2'd1: r_s2 <= clamp_unit(sn_raw);
                    2'd2: r_c1 <= clamp_unit(cs_raw);
                    2'd3: r_c2 <= clamp_unit(cs_raw);
                endcase
            end
            OP_TU: begin
                if (i_cmd.sel[0]) begin
                    r_u <= TRG_W'(rnd);
                end else begin
                    r_t <= TRG_W'(rnd);
                end
            end
            OP_ACLAMP: begin
                if (r_acc < 0) begin
                    r_a <= '0;
                end else if (r_acc > PROD_W'(ONE_Q60)) begin
                    r_a <= ONE_Q60;
                end else begin
                    r_a <= r_acc[A_W-1:0];
                end
            end
            OP_SQINIT: begin
                r_n   <= i_cmd.sel[0] ? SQ_W'(ONE_Q60 - r_a) : SQ_W'(r_a);
                r_res <= '0;
                r_bit <= SQ_BIT_START;
            end
            OP_SQSTEP: begin
                if (r_n >= trial) begin
                    r_n   <= r_n - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_SQSAVE: begin
                if (i_cmd.sel[0]) begin
                    r_xb <= r_res[31:0];
                end else begin
                    r_ya <= r_res[31:0];
                end
            end
            OP_VINIT: begin
                r_x <= {2'b0, r_xb};
                r_y <= {2'b0, r_ya};
                r_z <= '0;
            end
            OP_VEC: begin
                if (!r_y[CRD_W-1]) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end
            end
            OP_DIST: r_dist <= (dd > PROD_W'(MAX_DIST)) ? MAX_DIST : dd[DIST_W-1:0];
            OP_CMP: begin
                for (int k = 0; k < STORE_DEPTH; k++) begin
                    r_le[k] <= (k < int'(r_count)) && (r_kd[k] <= r_dist);
                end
            end
            OP_INS: begin
                for (int k = 0; k < STORE_DEPTH; k++) begin
                    if (!r_le[k]) begin
                        if (k == 0 || r_le[(k == 0) ? 0 : k - 1]) begin
                            r_kl[k] <= r_plat;
                            r_kn[k] <= r_plon;
                            r_ka[k] <= r_pattr;
                            r_kd[k] <= r_dist;
                        end else begin
                            r_kl[k] <= r_kl[(k == 0) ? 0 : k - 1];
                            r_kn[k] <= r_kn[(k == 0) ? 0 : k - 1];
                            r_ka[k] <= r_ka[(k == 0) ? 0 : k - 1];
                            r_kd[k] <= r_kd[(k == 0) ? 0 : k - 1];
                        end
                    end
                end
            end
            OP_EMIT: begin
                if (r_count == '0) begin
                    r_o_lat  <= '0;
                    r_o_lon  <= '0;
                    r_o_attr <= '0;
                    r_o_dist <= '0;
                    r_o_none <= 1'b1;
                    r_o_ovf  <= 1'b0;
                end else begin
                    r_o_lat  <= r_kl[0];
                    r_o_lon  <= r_kn[0];
                    r_o_attr <= r_ka[0];
                    r_o_dist <= r_kd[0];
                    r_o_none <= 1'b0;
                    r_o_ovf  <= r_ovf;
                end
                r_o_last <= (r_count <= CNT_W'(1));
                for (int k = 0; k < STORE_DEPTH; k++) begin
                    r_kl[k] <= r_kl[(k == STORE_DEPTH - 1) ? k : k + 1];
                    r_kn[k] <= r_kn[(k == STORE_DEPTH - 1) ? k : k + 1];
                    r_ka[k] <= r_ka[(k == STORE_DEPTH - 1) ? k : k + 1];
                    r_kd[k] <= r_kd[(k == STORE_DEPTH - 1) ? k : k + 1];
                end
            end
            default: ;
        endcase
    end

    assign o_status.step_last = (r_i == STEP_W'(CORDIC_STEPS - 1));
    assign o_status.sq_last   = (r_i == SQ_LAST_STEP);
    assign o_status.ya_zero   = (r_ya == '0);
    assign o_status.in_radius = (r_dist <= r_radius);
    assign o_status.cnt_le1   = (r_count <= CNT_W'(1));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_out_latitude  = r_o_lat;
    assign o_out_longitude = r_o_lon;
    assign o_out_attr      = r_o_attr;
    assign o_out_distance  = r_o_dist;
    assign o_none_found    = r_o_none;
    assign o_overflowed    = r_o_ovf;
    assign o_last_of_list  = r_o_last;

endmodule

@@ sv/grfs_ctrl.sv @@
// grfs_ctrl: sequencer that steps the datapath through the distance
// computation, sorted insert and list emission. Depends on grfs_pkg.
module grfs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [grfs_pkg::CMD_W-1:0]    i_command,
    input  grfs_pkg::t_status             i_status,
    output grfs_pkg::t_cmd                o_cmd
);
    import grfs_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ANG  = 5'd1;
    localparam logic [4:0] S_RED  = 5'd2;
    localparam logic [4:0] S_QUAD = 5'd3;
    localparam logic [4:0] S_MLO  = 5'd4;
    localparam logic [4:0] S_ALO  = 5'd5;
    localparam logic [4:0] S_MHI  = 5'd6;
    localparam logic [4:0] S_AHI  = 5'd7;
    localparam logic [4:0] S_ZI   = 5'd8;
    localparam logic [4:0] S_ROT  = 5'd9;
    localparam logic [4:0] S_TRIG = 5'd10;
    localparam logic [4:0] S_MT   = 5'd11;
    localparam logic [4:0] S_T    = 5'd12;
    localparam logic [4:0] S_MU   = 5'd13;
    localparam logic [4:0] S_U    = 5'd14;
    localparam logic [4:0] S_MS   = 5'd15;
    localparam logic [4:0] S_AS   = 5'd16;
    localparam logic [4:0] S_MTU  = 5'd17;
    localparam logic [4:0] S_ATU  = 5'd18;
    localparam logic [4:0] S_AC   = 5'd19;
    localparam logic [4:0] S_SQI  = 5'd20;
    localparam logic [4:0] S_SQ   = 5'd21;
    localparam logic [4:0] S_SQS  = 5'd22;
    localparam logic [4:0] S_VI   = 5'd23;
    localparam logic [4:0] S_VEC  = 5'd24;
    localparam logic [4:0] S_MD   = 5'd25;
    localparam logic [4:0] S_DIST = 5'd26;
    localparam logic [4:0] S_CMP  = 5'd27;
    localparam logic [4:0] S_INS  = 5'd28;
    localparam logic [4:0] S_FIN  = 5'd29;

    logic [4:0] r_state, n_state;
    logic [1:0] r_j, n_j;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        o_cmd   = '{op: OP_NOP, sel: 3'd0};
        unique case (r_state)
            S_IDLE: begin
                n_j = 2'd0;
                if (accept) begin
                    priority case (i_command)
                        CMD_ADD: begin
                            o_cmd.op = OP_LOAD;
                            n_state  = S_ANG;
                        end
                        CMD_FINISH: n_state = S_FIN;
                        CMD_CLEAR:  o_cmd.op = OP_CLR;
                        default:    ;
                    endcase
                end
            end
            S_ANG:  begin o_cmd = '{op: OP_ANGLE, sel: {1'b0, r_j}}; n_state = S_RED; end
            S_RED:  begin o_cmd.op = OP_REDUCE; n_state = S_QUAD; end
            S_QUAD: begin o_cmd.op = OP_QUAD; n_state = S_MLO; end
            S_MLO:  begin o_cmd = '{op: OP_MUL, sel: MS_KL}; n_state = S_ALO; end
            S_ALO:  begin o_cmd.op = OP_ACCSET; n_state = S_MHI; end
            S_MHI:  begin o_cmd = '{op: OP_MUL, sel: MS_KH}; n_state = S_AHI; end
            S_AHI:  begin o_cmd = '{op: OP_ACCADD, sel: 3'd1}; n_state = S_ZI; end
            S_ZI:   begin o_cmd.op = OP_ZINIT; n_state = S_ROT; end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                if (i_status.step_last) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                o_cmd   = '{op: OP_TRIG, sel: {1'b0, r_j}};
                n_j     = r_j + 1'b1;
                n_state = (r_j == 2'd3) ? S_MT : S_ANG;
            end
            S_MT:  begin o_cmd = '{op: OP_MUL, sel: MS_C1S2}; n_state = S_T; end
            S_T:   begin o_cmd = '{op: OP_TU, sel: 3'd0}; n_state = S_MU; end
            S_MU:  begin o_cmd = '{op: OP_MUL, sel: MS_C2S2}; n_state = S_U; end
            S_U:   begin o_cmd = '{op: OP_TU, sel: 3'd1}; n_state = S_MS; end
            S_MS:  begin o_cmd = '{op: OP_MUL, sel: MS_S1S1}; n_state = S_AS; end
            S_AS:  begin o_cmd.op = OP_ACCSET; n_state = S_MTU; end
            S_MTU: begin o_cmd = '{op: OP_MUL, sel: MS_TU}; n_state = S_ATU; end
            S_ATU: begin o_cmd = '{op: OP_ACCADD, sel: 3'd0}; n_state = S_AC; end
            S_AC:  begin o_cmd.op = OP_ACLAMP; n_state = S_SQI; end
            S_SQI: begin o_cmd = '{op: OP_SQINIT, sel: {1'b0, r_j}}; n_state = S_SQ; end
            S_SQ: begin
                o_cmd.op = OP_SQSTEP;
                if (i_status.sq_last) begin
                    n_state = S_SQS;
                end
            end
            S_SQS: begin
                o_cmd   = '{op: OP_SQSAVE, sel: {1'b0, r_j}};
                n_j     = r_j + 1'b1;
                n_state = (r_j == 2'd0) ? S_SQI : S_VI;
            end
            S_VI: begin
                o_cmd.op = OP_VINIT;
                n_state  = i_status.ya_zero ? S_MD : S_VEC;
            end
            S_VEC: begin
                o_cmd.op = OP_VEC;
                if (i_status.step_last) begin
                    n_state = S_MD;
                end
            end
            S_MD:   begin o_cmd = '{op: OP_MUL, sel: MS_Z}; n_state = S_DIST; end
            S_DIST: begin o_cmd.op = OP_DIST; n_state = S_CMP; end
            S_CMP:  begin o_cmd.op = OP_CMP; n_state = S_INS; end
            S_INS: begin
                o_cmd.op = i_status.in_radius ? OP_INS : OP_NOP;
                n_state  = S_IDLE;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    if (i_status.cnt_le1) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
        end
    end

endmodule
